@@ sv/cau_pkg.sv @@
// Shared types and constants for the complex arithmetic unit.
package cau_pkg;

	localparam int CAU_DATA_W    = 32;
	localparam int CAU_FRAC_BITS = 16;
	localparam int CAU_DIV_STEPS = 4;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SUB = 2'd1,
		CMD_MUL = 2'd2,
		CMD_DIV = 2'd3
	} cau_cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIVZ = 2'd2
	} cau_status_t;

	typedef struct packed {
		cau_cmd_t                      cmd;
		logic signed [CAU_DATA_W-1:0]  a_re;
		logic signed [CAU_DATA_W-1:0]  a_im;
		logic signed [CAU_DATA_W-1:0]  b_re;
		logic signed [CAU_DATA_W-1:0]  b_im;
	} req_t;

	typedef struct packed {
		logic signed [CAU_DATA_W-1:0]  res_re;
		logic signed [CAU_DATA_W-1:0]  res_im;
		cau_status_t                   status;
	} rsp_t;

endpackage

@@ sv/cau_mul.sv @@
// Two-stage signed multiplier built from four half-width partial products.
module cau_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [AW-1:0]     a,
	input  logic signed [BW-1:0]     b,
	output logic signed [AW+BW-1:0]  p
);

	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = BW / 2;
	localparam int BH = BW - BL;
	localparam int PW = AW + BW;

	logic signed [AH-1:0]      ah;
	logic        [AL-1:0]      al;
	logic signed [BH-1:0]      bh;
	logic        [BL-1:0]      bl;
	logic signed [AH+BH-1:0]   hh_s1;
	logic signed [AH+BL:0]     hl_s1;
	logic signed [AL+BH:0]     lh_s1;
	logic        [AL+BL-1:0]   ll_s1;

	assign ah = $signed(a[AW-1:AL]);
	assign al = a[AL-1:0];
	assign bh = $signed(b[BW-1:BL]);
	assign bl = b[BL-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1 <= ah * bh;
			hl_s1 <= ah * $signed({1'b0, bl});
			lh_s1 <= $signed({1'b0, al}) * bh;
			ll_s1 <= al * bl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= (PW'(hh_s1) <<< (AL + BL)) + (PW'(hl_s1) <<< AL)
				+ (PW'(lh_s1) <<< BL) + PW'(ll_s1);
		end
	end

endmodule

@@ sv/cau_div.sv @@
// Pipelined unsigned restoring divider, STEPS quotient bits per stage.
module cau_div #(
	parameter int NW    = 48,
	parameter int DW    = 32,
	parameter int QB    = 17,
	parameter int STEPS = 4
) (
	input  logic           clk,
	input  logic           en,
	input  logic [NW-1:0]  num,
	input  logic [DW-1:0]  den,
	output logic [QB-1:0]  quo
);

	localparam int LAT = (QB + STEPS - 1) / STEPS;

	// remainder, dividend bits still to shift in (quotient fills from the bottom), divisor
	logic [DW-1:0] rem_s [1:LAT];
	logic [QB-1:0] low_s [1:LAT];
	logic [DW-1:0] dv_s  [1:LAT];

	for (genvar j = 0; j < LAT; j++) begin : g_stage
		logic [DW-1:0] rem_i;
		logic [QB-1:0] low_i;
		logic [DW-1:0] dv_i;
		logic [DW-1:0] rem_n;
		logic [QB-1:0] low_n;

		if (j == 0) begin : g_first
			assign rem_i = DW'(num >> QB);
			assign low_i = num[QB-1:0];
			assign dv_i  = den;
		end else begin : g_next
			assign rem_i = rem_s[j];
			assign low_i = low_s[j];
			assign dv_i  = dv_s[j];
		end

		always_comb begin
			logic [DW:0] t;
			rem_n = rem_i;
			low_n = low_i;
			for (int i = 0; i < STEPS; i++) begin
				if (j * STEPS + i < QB) begin
					t = {rem_n, low_n[QB-1]};
					low_n = low_n << 1;
					if (t >= {1'b0, dv_i}) begin
						rem_n = DW'(t - {1'b0, dv_i});
						low_n[0] = 1'b1;
					end else begin
						rem_n = t[DW-1:0];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= rem_n;
				low_s[j+1] <= low_n;
				dv_s[j+1]  <= dv_i;
			end
		end
	end

	assign quo = low_s[LAT];

endmodule

@@ sv/complex_arith_unit.sv @@
// Complex add, subtract, multiply and Smith divide on signed fixed point, fully pipelined.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  req     | in  | req_valid / req_ready  | cmd, a_re, a_im, b_re, b_im (req_t)
//  rsp     | out | rsp_valid / rsp_ready  | res_re, res_im, status (rsp_t)
//
//  One transaction per cycle in, one result per cycle out, while the result is not stalled.
//  Pipeline depth is set mainly by the ratio divider and the two quotient dividers.
//  Reset clears all valid bits; no other state.
//  A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module complex_arith_unit import cau_pkg::*; #(
	parameter int FRAC_BITS = CAU_FRAC_BITS,
	parameter int DIV_STEPS = CAU_DIV_STEPS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  req_t  req,
	output logic  rsp_valid,
	input  logic  rsp_ready,
	output rsp_t  rsp
);

	localparam int W      = CAU_DATA_W;
	localparam int F      = FRAC_BITS;
	localparam int SW     = (2 * W + 2 > W + F + 3) ? 2 * W + 2 : W + F + 3;
	localparam int LR     = (F + 1 + DIV_STEPS - 1) / DIV_STEPS;
	localparam int LQ     = (W + F + 1 + DIV_STEPS - 1) / DIV_STEPS;
	localparam int K_RAT  = 1 + LR;
	localparam int K_LAST = K_RAT + 6 + LQ;

	localparam logic signed [SW-1:0] SMAX = {{(SW - W + 1){1'b0}}, {(W - 1){1'b1}}};
	localparam logic signed [SW-1:0] SMIN = ~SMAX;

	typedef struct packed {
		cau_cmd_t             op;
		logic                 zero;
		logic                 rsgn;
		logic signed [W-1:0]  bd;
		logic signed [W:0]    xp;
		logic signed [W:0]    up;
		logic signed [W:0]    xq;
		logic signed [W:0]    uq;
		logic [W-1:0]         e_re;
		logic [W-1:0]         e_im;
		cau_status_t          e_st;
		logic signed [W+2:0]  nr;
		logic signed [W+2:0]  ni;
		logic [F+1:0]         onesq;
		logic signed [W+2:0]  den;
	} side_t;

	function automatic logic [W:0] sat_fn(input logic signed [SW-1:0] v);
		logic [W:0] r;
		if (v > SMAX) begin
			r = {1'b1, SMAX[W-1:0]};
		end else if (v < SMIN) begin
			r = {1'b1, SMIN[W-1:0]};
		end else begin
			r = {1'b0, v[W-1:0]};
		end
		return r;
	endfunction

	logic              adv;
	logic [K_LAST:1]   vld_s;
	req_t              req_s1;
	side_t             side_s [2:K_LAST];
	side_t             prep_c;
	logic [W-1:0]      rd_nm;
	logic [W-1:0]      rd_dm;
	logic [W+F-1:0]    rd_num;
	logic [F:0]        rd_q;
	logic              out_vld_q;
	rsp_t              out_q;

	assign adv       = !out_vld_q || rsp_ready;
	assign req_ready = adv;
	assign rsp_valid = out_vld_q;
	assign rsp       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s     <= {vld_s[K_LAST-1:1], req_valid};
			out_vld_q <= vld_s[K_LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= req;
		end
	end

	// operand prep: branch choice, ratio operands, add/sub result
	always_comb begin
		logic [W-1:0]         bre_mag;
		logic [W-1:0]         bim_mag;
		logic                 br1;
		logic signed [SW-1:0] vr;
		logic signed [SW-1:0] vi;
		logic [W:0]           sr;
		logic [W:0]           si;
		bre_mag = req_s1.b_re[W-1] ? W'(-req_s1.b_re) : W'(req_s1.b_re);
		bim_mag = req_s1.b_im[W-1] ? W'(-req_s1.b_im) : W'(req_s1.b_im);
		br1     = bim_mag >= bre_mag;
		rd_nm   = br1 ? bre_mag : bim_mag;
		rd_dm   = br1 ? bim_mag : bre_mag;
		rd_num  = (W + F)'(rd_nm) << F;

		prep_c      = '0;
		prep_c.op   = req_s1.cmd;
		prep_c.zero = (req_s1.b_re == '0) && (req_s1.b_im == '0);
		prep_c.rsgn = br1 ? (req_s1.b_re[W-1] ^ req_s1.b_im[W-1])
		                  : !(req_s1.b_re[W-1] ^ req_s1.b_im[W-1]);
		prep_c.bd   = br1 ? req_s1.b_im : req_s1.b_re;
		prep_c.xp   = br1 ? (W + 1)'(req_s1.a_re) : -((W + 1)'(req_s1.a_im));
		prep_c.up   = br1 ? (W + 1)'(req_s1.a_im) : (W + 1)'(req_s1.a_re);
		prep_c.xq   = br1 ? (W + 1)'(req_s1.a_im) : (W + 1)'(req_s1.a_re);
		prep_c.uq   = br1 ? -((W + 1)'(req_s1.a_re)) : (W + 1)'(req_s1.a_im);

		if (req_s1.cmd == CMD_SUB) begin
			vr = SW'(req_s1.a_re) - SW'(req_s1.b_re);
			vi = SW'(req_s1.a_im) - SW'(req_s1.b_im);
		end else begin
			vr = SW'(req_s1.a_re) + SW'(req_s1.b_re);
			vi = SW'(req_s1.a_im) + SW'(req_s1.b_im);
		end
		sr          = sat_fn(vr);
		si          = sat_fn(vi);
		prep_c.e_re = sr[W-1:0];
		prep_c.e_im = si[W-1:0];
		prep_c.e_st = (sr[W] || si[W]) ? ST_SAT : ST_OK;
	end

	// ratio of smaller to larger divisor part
	cau_div #(.NW(W + F), .DW(W), .QB(F + 1), .STEPS(DIV_STEPS)) u_div_ratio (
		.clk (clk), .en (adv), .num (rd_num), .den (rd_dm), .quo (rd_q)
	);

	// full products for multiply
	logic signed [2*W-1:0] p_rr, p_ii, p_ri, p_ir;

	cau_mul #(.AW(W), .BW(W)) u_mul_rr (
		.clk (clk), .en (adv), .a (req_s1.a_re), .b (req_s1.b_re), .p (p_rr));
	cau_mul #(.AW(W), .BW(W)) u_mul_ii (
		.clk (clk), .en (adv), .a (req_s1.a_im), .b (req_s1.b_im), .p (p_ii));
	cau_mul #(.AW(W), .BW(W)) u_mul_ri (
		.clk (clk), .en (adv), .a (req_s1.a_re), .b (req_s1.b_im), .p (p_ri));
	cau_mul #(.AW(W), .BW(W)) u_mul_ir (
		.clk (clk), .en (adv), .a (req_s1.a_im), .b (req_s1.b_re), .p (p_ir));

	logic [W-1:0] mul_re, mul_im;
	cau_status_t  mul_st;

	always_comb begin
		logic signed [2*W:0] mr;
		logic signed [2*W:0] mi;
		logic [W:0]          sr;
		logic [W:0]          si;
		mr     = (2 * W + 1)'(p_rr) - (2 * W + 1)'(p_ii);
		mi     = (2 * W + 1)'(p_ri) + (2 * W + 1)'(p_ir);
		sr     = sat_fn(SW'(mr >>> F));
		si     = sat_fn(SW'(mi >>> F));
		mul_re = sr[W-1:0];
		mul_im = si[W-1:0];
		mul_st = (sr[W] || si[W]) ? ST_SAT : ST_OK;
	end

	// ratio squared and numerator products
	logic signed [F+1:0]     ratio;
	logic signed [2*F+3:0]   sq_p;
	logic signed [W+F+2:0]   np_p;
	logic signed [W+F+2:0]   nq_p;

	assign ratio = side_s[K_RAT].rsgn ? -$signed({1'b0, rd_q}) : $signed({1'b0, rd_q});

	cau_mul #(.AW(F + 2), .BW(F + 2)) u_mul_sq (
		.clk (clk), .en (adv), .a (ratio), .b (ratio), .p (sq_p));
	cau_mul #(.AW(W + 1), .BW(F + 2)) u_mul_np (
		.clk (clk), .en (adv), .a (side_s[K_RAT].xp), .b (ratio), .p (np_p));
	cau_mul #(.AW(W + 1), .BW(F + 2)) u_mul_nq (
		.clk (clk), .en (adv), .a (side_s[K_RAT].xq), .b (ratio), .p (nq_p));

	logic [F+1:0]         c_onesq;
	logic signed [W+2:0]  c_nr, c_ni;

	assign c_onesq = {1'b0, sq_p[2*F:F]} + ((F + 2)'(1) << F);
	assign c_nr    = $signed(np_p[W+F+2:F]) + (W + 3)'(side_s[K_RAT+2].up);
	assign c_ni    = $signed(nq_p[W+F+2:F]) + (W + 3)'(side_s[K_RAT+2].uq);

	// scaled divisor
	logic signed [W+F+2:0] dp_p;
	logic signed [W+2:0]   c_den;

	cau_mul #(.AW(W), .BW(F + 3)) u_mul_den (
		.clk (clk), .en (adv), .a (side_s[K_RAT+3].bd),
		.b ($signed({1'b0, side_s[K_RAT+3].onesq})), .p (dp_p));

	assign c_den = $signed(dp_p[W+F+2:F]);

	// quotient dividers
	logic [W:0]       fd_dmag, fd_nrmag, fd_nimag;
	logic [W+2:0]     fd_dabs, fd_nrabs, fd_niabs;
	logic [W+F:0]     fd_nr, fd_ni;
	logic [W+F:0]     q_re, q_im;

	assign fd_dabs  = side_s[K_RAT+6].den[W+2] ? -side_s[K_RAT+6].den : side_s[K_RAT+6].den;
	assign fd_nrabs = side_s[K_RAT+6].nr[W+2] ? -side_s[K_RAT+6].nr : side_s[K_RAT+6].nr;
	assign fd_niabs = side_s[K_RAT+6].ni[W+2] ? -side_s[K_RAT+6].ni : side_s[K_RAT+6].ni;
	assign fd_dmag  = fd_dabs[W:0];
	assign fd_nrmag = fd_nrabs[W:0];
	assign fd_nimag = fd_niabs[W:0];
	assign fd_nr    = (W + F + 1)'(fd_nrmag) << F;
	assign fd_ni    = (W + F + 1)'(fd_nimag) << F;

	cau_div #(.NW(W + F + 1), .DW(W + 1), .QB(W + F + 1), .STEPS(DIV_STEPS)) u_div_re (
		.clk (clk), .en (adv), .num (fd_nr), .den (fd_dmag), .quo (q_re));
	cau_div #(.NW(W + F + 1), .DW(W + 1), .QB(W + F + 1), .STEPS(DIV_STEPS)) u_div_im (
		.clk (clk), .en (adv), .num (fd_ni), .den (fd_dmag), .quo (q_im));

	// side-band pipeline
	for (genvar k = 2; k <= K_LAST; k++) begin : g_side
		side_t nxt;

		if (k == 2) begin : g_prep
			assign nxt = prep_c;
		end else if (k == 4) begin : g_mul
			always_comb begin
				nxt = side_s[k-1];
				if (side_s[k-1].op == CMD_MUL) begin
					nxt.e_re = mul_re;
					nxt.e_im = mul_im;
					nxt.e_st = mul_st;
				end
			end
		end else if (k == K_RAT + 3) begin : g_num
			always_comb begin
				nxt       = side_s[k-1];
				nxt.nr    = c_nr;
				nxt.ni    = c_ni;
				nxt.onesq = c_onesq;
			end
		end else if (k == K_RAT + 6) begin : g_den
			always_comb begin
				nxt     = side_s[k-1];
				nxt.den = c_den;
			end
		end else begin : g_pass
			assign nxt = side_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= nxt;
			end
		end
	end

	// result select and output register
	rsp_t out_c;

	always_comb begin
		logic                   sgn_r;
		logic                   sgn_i;
		logic signed [W+F+1:0]  xr;
		logic signed [W+F+1:0]  xi;
		logic [W:0]             sr;
		logic [W:0]             si;
		sgn_r = side_s[K_LAST].nr[W+2] ^ side_s[K_LAST].den[W+2];
		sgn_i = side_s[K_LAST].ni[W+2] ^ side_s[K_LAST].den[W+2];
		xr    = sgn_r ? -$signed({1'b0, q_re}) : $signed({1'b0, q_re});
		xi    = sgn_i ? -$signed({1'b0, q_im}) : $signed({1'b0, q_im});
		sr    = sat_fn(SW'(xr));
		si    = sat_fn(SW'(xi));
		if (side_s[K_LAST].op != CMD_DIV) begin
			out_c.res_re = side_s[K_LAST].e_re;
			out_c.res_im = side_s[K_LAST].e_im;
			out_c.status = side_s[K_LAST].e_st;
		end else if (side_s[K_LAST].zero) begin
			out_c.res_re = '0;
			out_c.res_im = '0;
			out_c.status = ST_DIVZ;
		end else begin
			out_c.res_re = sr[W-1:0];
			out_c.res_im = si[W-1:0];
			out_c.status = (sr[W] || si[W]) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= out_c;
		end
	end

	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_DIVZ |-> rsp.res_re == '0 && rsp.res_im == '0)
		else $error("division by zero with nonzero result");

	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_s[K_LAST] |=> rsp_valid)
		else $error("finished transaction lost at output register");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s))
		else $error("pipeline moved during stall");

	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> rsp_valid && !rsp_ready)
		else $error("input stalled without output backpressure");

endmodule
